@@ src/fdec_pkg.sv @@
// shared types, constants and base-encoding tables of the font code decoder
`timescale 1ns / 1ps
`default_nettype none
package fdec_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 40;

  typedef enum logic [1:0] {
    MODE_DECODE = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMAPPED  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_KEEP  = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESOLVE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] n;
    status_t    st;
  } res_t;

  localparam logic [15:0] WIN_HI [32] = '{
    16'h20AC, 16'h2022, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  localparam logic [15:0] MAC_HI [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  function automatic logic [15:0] doc_lookup(input logic [7:0] c);
    logic [15:0] s;
    begin
      unique case (c)
        8'h18: s = 16'h02D8;  8'h19: s = 16'h02C7;  8'h1A: s = 16'h02C6;
        8'h1B: s = 16'h02D9;  8'h1C: s = 16'h02DD;  8'h1D: s = 16'h02DB;
        8'h1E: s = 16'h02DA;  8'h1F: s = 16'h02DC;  8'h80: s = 16'h2022;
        8'h81: s = 16'h2020;  8'h82: s = 16'h2021;  8'h83: s = 16'h2026;
        8'h84: s = 16'h2014;  8'h85: s = 16'h2013;  8'h86: s = 16'h0192;
        8'h87: s = 16'h2044;  8'h88: s = 16'h2039;  8'h89: s = 16'h203A;
        8'h8A: s = 16'h2212;  8'h8B: s = 16'h2030;  8'h8C: s = 16'h201E;
        8'h8D: s = 16'h201C;  8'h8E: s = 16'h201D;  8'h8F: s = 16'h2018;
        8'h90: s = 16'h2019;  8'h91: s = 16'h201A;  8'h92: s = 16'h2122;
        8'h93: s = 16'hFB01;  8'h94: s = 16'hFB02;  8'h95: s = 16'h0141;
        8'h96: s = 16'h0152;  8'h97: s = 16'h0160;  8'h98: s = 16'h0178;
        8'h99: s = 16'h017D;  8'h9A: s = 16'h0131;  8'h9B: s = 16'h0142;
        8'h9C: s = 16'h0153;  8'h9D: s = 16'h0161;  8'h9E: s = 16'h017E;
        8'hA0: s = 16'h20AC;
        default: s = 16'h0000;
      endcase
      return s;
    end
  endfunction

  function automatic logic [15:0] std_lookup(input logic [7:0] c);
    logic [15:0] s;
    begin
      unique case (c)
        8'h27: s = 16'h2019;  8'h60: s = 16'h2018;  8'hA1: s = 16'h00A1;
        8'hA2: s = 16'h00A2;  8'hA3: s = 16'h00A3;  8'hA4: s = 16'h2044;
        8'hA5: s = 16'h00A5;  8'hA6: s = 16'h0192;  8'hA7: s = 16'h00A7;
        8'hA8: s = 16'h00A4;  8'hA9: s = 16'h0027;  8'hAA: s = 16'h201C;
        8'hAB: s = 16'h00AB;  8'hAC: s = 16'h2039;  8'hAD: s = 16'h203A;
        8'hAE: s = 16'hFB01;  8'hAF: s = 16'hFB02;  8'hB1: s = 16'h2013;
        8'hB2: s = 16'h2020;  8'hB3: s = 16'h2021;  8'hB4: s = 16'h00B7;
        8'hB6: s = 16'h00B6;  8'hB7: s = 16'h2022;  8'hB8: s = 16'h201A;
        8'hB9: s = 16'h201E;  8'hBA: s = 16'h201D;  8'hBB: s = 16'h00BB;
        8'hBC: s = 16'h2026;  8'hBD: s = 16'h2030;  8'hBF: s = 16'h00BF;
        8'hC1: s = 16'h0060;  8'hC2: s = 16'h00B4;  8'hC3: s = 16'h02C6;
        8'hC4: s = 16'h02DC;  8'hC5: s = 16'h00AF;  8'hC6: s = 16'h02D8;
        8'hC7: s = 16'h02D9;  8'hC8: s = 16'h00A8;  8'hCA: s = 16'h02DA;
        8'hCB: s = 16'h00B8;  8'hCD: s = 16'h02DD;  8'hCE: s = 16'h02DB;
        8'hCF: s = 16'h02C7;  8'hD0: s = 16'h2014;  8'hE1: s = 16'h00C6;
        8'hE3: s = 16'h00AA;  8'hE8: s = 16'h0141;  8'hE9: s = 16'h00D8;
        8'hEA: s = 16'h0152;  8'hEB: s = 16'h00BA;  8'hF1: s = 16'h00E6;
        8'hF5: s = 16'h0131;  8'hF8: s = 16'h0142;  8'hF9: s = 16'h00F8;
        8'hFA: s = 16'h0153;  8'hFB: s = 16'h00DF;
        default: s = 16'h0000;
      endcase
      return s;
    end
  endfunction

  // base encoding scalar of a code, zero when unmapped
  function automatic logic [15:0] base_lookup(input logic [3:0] b, input logic [7:0] c);
    logic [15:0] sm;
    logic [15:0] sd;
    logic [15:0] s;
    begin
      sm = std_lookup(c);
      sd = doc_lookup(c);
      s  = 16'h0000;
      if (b == 4'd5 && c == 8'h63) s = 16'h03B3;
      else if (b == 4'd5 && c == 8'h64) s = 16'h03B4;
      else if (b == 4'd5 && c == 8'h6C) s = 16'h03BB;
      else if (b == 4'd8 && c == 8'h6F) s = 16'h2610;
      else if (b == 4'd9 && c == 8'hD3) s = 16'h2191;
      else if (b == 4'd3 && sm != 16'h0000) s = sm;
      else if (c >= 8'h20 && c <= 8'h7E) s = {8'h00, c};
      else begin
        unique case (b)
          4'd0: begin
            if (c >= 8'hA0) s = {8'h00, c};
            else if (c[7]) s = WIN_HI[c[4:0]];
            else s = 16'h0000;
          end
          4'd1: s = c[7] ? MAC_HI[c[6:0]] : 16'h0000;
          4'd2: begin
            if (sd != 16'h0000) s = sd;
            else if (c >= 8'hA1) s = {8'h00, c};
            else s = 16'h0000;
          end
          4'd4: s = (c == 8'h00) ? 16'h2212 : sm;
          4'd6: begin
            if (c == 8'h02) s = 16'h00B0;
            else if (c == 8'h03) s = 16'h223C;
            else if (c == 8'h04) s = 16'h2248;
            else s = sm;
          end
          4'd7: begin
            if (c == 8'h02) s = 16'h030C;
            else if (c == 8'h03) s = 16'h0301;
            else s = sm;
          end
          4'd3, 4'd5: s = sm;
          default: s = 16'h0000;
        endcase
      end
      return s;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/fdec_diff_ram.sv @@
// difference table memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fdec_diff_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [fdec_pkg::AW-1:0]      waddr,
  input  wire logic [fdec_pkg::ENTRY_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [fdec_pkg::AW-1:0]      raddr,
  output logic      [fdec_pkg::ENTRY_W-1:0] rdata
);
  import fdec_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/fdec_emit.sv @@
// turns a resolved mapping into packed bytes, ligature letters or utf-8
`timescale 1ns / 1ps
`default_nettype none
module fdec_emit (
  input  wire logic [31:0]   scalar,
  output fdec_pkg::res_t     res
);
  import fdec_pkg::*;

  logic [6:0] len;

  assign len = scalar[30:24];

  always_comb begin
    res    = '0;
    res.st = ST_OK;
    if (scalar == 32'h0) begin
      res.st = ST_UNMAPPED;
    end else if (scalar[31]) begin
      if (len == 7'd2 || len == 7'd3) begin
        res.b0 = scalar[23:16];
        res.b1 = scalar[15:8];
        res.b2 = (len == 7'd3) ? scalar[7:0] : 8'h00;
        res.n  = len[2:0];
      end else begin
        res.st = ST_MALFORMED;
      end
    end else if (scalar >= 32'hFB00 && scalar <= 32'hFB06) begin
      unique case (scalar[2:0])
        3'd0: begin res.b0 = 8'h66; res.b1 = 8'h66; res.n = 3'd2; end
        3'd1: begin res.b0 = 8'h66; res.b1 = 8'h69; res.n = 3'd2; end
        3'd2: begin res.b0 = 8'h66; res.b1 = 8'h6C; res.n = 3'd2; end
        3'd3: begin res.b0 = 8'h66; res.b1 = 8'h66; res.b2 = 8'h69; res.n = 3'd3; end
        3'd4: begin res.b0 = 8'h66; res.b1 = 8'h66; res.b2 = 8'h6C; res.n = 3'd3; end
        3'd5, 3'd6: begin res.b0 = 8'h73; res.b1 = 8'h74; res.n = 3'd2; end
        default: res.n = 3'd0;
      endcase
    end else if (scalar < 32'h80) begin
      res.b0 = scalar[7:0];
      res.n  = 3'd1;
    end else if (scalar < 32'h800) begin
      res.b0 = {3'b110, scalar[10:6]};
      res.b1 = {2'b10, scalar[5:0]};
      res.n  = 3'd2;
    end else if (scalar < 32'h10000) begin
      if (scalar >= 32'hD800 && scalar <= 32'hDFFF) begin
        res.st = ST_INVALID;
      end else begin
        res.b0 = {4'b1110, scalar[15:12]};
        res.b1 = {2'b10, scalar[11:6]};
        res.b2 = {2'b10, scalar[5:0]};
        res.n  = 3'd3;
      end
    end else if (scalar <= 32'h10FFFF) begin
      res.b0 = {5'b11110, scalar[20:18]};
      res.b1 = {2'b10, scalar[17:12]};
      res.b2 = {2'b10, scalar[11:6]};
      res.b3 = {2'b10, scalar[5:0]};
      res.n  = 3'd4;
    end else begin
      res.st = ST_INVALID;
    end
  end

endmodule
`default_nettype wire

@@ src/font_code_to_utf8_decoder.sv @@
// top level: font code to utf-8 decoder with a difference table in memory
//
//  channel | ports                                   | dir
//  in      | in_valid/in_ready, mode code new_scalar kept_entries | in
//  out     | out_valid/out_ready, byte_0..3 byte_count status      | out
//  cfg     | cfg_valid/cfg_ready, cfg_base_encoding   | in
//
// add, clear and unused mode: result shown in the cycle after the input beat
// decode: entries scanned newest first (0 to entry count) in the search state,
// one entry a cycle through the single read port of the difference memory
// sync reset clears entry count, base encoding, state and the result valid flag
// one item in flight; a held result blocks the next input beat
`timescale 1ns / 1ps
`default_nettype none
module font_code_to_utf8_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_code,
  input  wire logic [31:0] in_new_scalar,
  input  wire logic [8:0]  in_kept_entries,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte_0,
  output logic [7:0]       out_byte_1,
  output logic [7:0]       out_byte_2,
  output logic [7:0]       out_byte_3,
  output logic [2:0]       out_byte_count,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_base_encoding
);
  import fdec_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [3:0]         base_r;
  logic [7:0]         code_r;
  logic [31:0]        scalar_r;
  logic [AW-1:0]      idx_r;
  logic               out_valid_r;
  res_t               res_r;
  res_t               emit_res;

  logic               in_fire;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               hit;
  logic               last;
  logic               full;
  logic               bad_keep;
  mode_t              mode;
  status_t            op_st;

  assign mode     = mode_t'(in_mode);
  assign in_fire  = in_valid && in_ready;
  assign full     = (32'(count_r) >= TABLE_DEPTH);
  assign bad_keep = (32'(in_kept_entries) > TABLE_DEPTH);
  assign hit      = (mem_rdata[ENTRY_W-1 -: 8] == code_r);
  assign last     = (idx_r == '0);
  assign op_st    = (mode == MODE_ADD && full) ? ST_FULL :
                    (mode == MODE_CLEAR && bad_keep) ? ST_BAD_KEEP : ST_OK;

  fdec_diff_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_code, in_new_scalar}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fdec_emit u_emit (
    .scalar (scalar_r),
    .res    (emit_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && mode == MODE_DECODE) begin
          state_nxt = (count_r == '0) ? S_RESOLVE : S_SEARCH;
        end
      end
      S_SEARCH:  if (hit || last) state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_EMIT;
      S_EMIT:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx_r - 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = !out_valid_r;
        mem_we    = in_fire && mode == MODE_ADD && !full;
        mem_re    = in_fire && mode == MODE_DECODE && count_r != '0;
        mem_raddr = AW'(count_r - 1'b1);
      end
      S_SEARCH: mem_re = !(hit || last);
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_base_encoding;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        unique case (mode)
          MODE_ADD: begin
            if (!full) count_r <= count_r + 1'b1;
            out_valid_r <= 1'b1;
          end
          MODE_CLEAR: begin
            if (!bad_keep) count_r <= CNT_W'(in_kept_entries);
            out_valid_r <= 1'b1;
          end
          MODE_NONE:   out_valid_r <= 1'b1;
          MODE_DECODE: out_valid_r <= 1'b0;
          default:     out_valid_r <= 1'b0;
        endcase
      end
      if (state_r == S_EMIT) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          code_r   <= in_code;
          scalar_r <= 32'h0;
          idx_r    <= AW'(count_r - 1'b1);
          res_r    <= '{b0: 8'h00, b1: 8'h00, b2: 8'h00, b3: 8'h00, n: 3'd0, st: op_st};
        end
      end
      S_SEARCH: begin
        if (hit) scalar_r <= mem_rdata[31:0];
        idx_r <= idx_r - 1'b1;
      end
      S_RESOLVE: begin
        // zero mapping falls through to the base encoding
        if (scalar_r == 32'h0) scalar_r <= {16'h0000, base_lookup(base_r, code_r)};
      end
      S_EMIT:  res_r <= emit_res;
      default: res_r <= res_r;
    endcase
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_byte_0     = res_r.b0;
  assign out_byte_1     = res_r.b1;
  assign out_byte_2     = res_r.b2;
  assign out_byte_3     = res_r.b3;
  assign out_byte_count = res_r.n;
  assign out_status     = res_r.st;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  a_fail_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_byte_count == 3'd0))
    else $error("failing result carries bytes");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready && !out_valid_r)
    else $error("input taken or result shown during decode");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated after accept");

endmodule
`default_nettype wire

@@ tb/sv/font_code_to_utf8_decoder_tb.sv @@
// testbench of the font code to utf-8 decoder: directed and random beats checked against a predictor
`timescale 1ns / 1ps
module font_code_to_utf8_decoder_tb;
  import fdec_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [7:0]  code;
    logic [31:0] scalar;
    logic [8:0]  kept;
  } glyph_req_t;

  localparam logic [31:0] PACKED_BIT = 32'h8000_0000;

  // {code, scalar} pairs of the document and standard base encodings
  localparam logic [23:0] DOC_PAIRS [40] = '{
    24'h1802D8, 24'h1902C7, 24'h1A02C6, 24'h1B02D9, 24'h1C02DD, 24'h1D02DB, 24'h1E02DA,
    24'h1F02DC, 24'h802022, 24'h812020, 24'h822021, 24'h832026, 24'h842014, 24'h852013,
    24'h860192, 24'h872044, 24'h882039, 24'h89203A, 24'h8A2212, 24'h8B2030, 24'h8C201E,
    24'h8D201C, 24'h8E201D, 24'h8F2018, 24'h902019, 24'h91201A, 24'h922122, 24'h93FB01,
    24'h94FB02, 24'h950141, 24'h960152, 24'h970160, 24'h980178, 24'h99017D, 24'h9A0131,
    24'h9B0142, 24'h9C0153, 24'h9D0161, 24'h9E017E, 24'hA020AC
  };
  localparam logic [23:0] STD_PAIRS [56] = '{
    24'h272019, 24'h602018, 24'hA100A1, 24'hA200A2, 24'hA300A3, 24'hA42044, 24'hA500A5,
    24'hA60192, 24'hA700A7, 24'hA800A4, 24'hA90027, 24'hAA201C, 24'hAB00AB, 24'hAC2039,
    24'hAD203A, 24'hAEFB01, 24'hAFFB02, 24'hB12013, 24'hB22020, 24'hB32021, 24'hB400B7,
    24'hB600B6, 24'hB72022, 24'hB8201A, 24'hB9201E, 24'hBA201D, 24'hBB00BB, 24'hBC2026,
    24'hBD2030, 24'hBF00BF, 24'hC10060, 24'hC200B4, 24'hC302C6, 24'hC402DC, 24'hC500AF,
    24'hC602D8, 24'hC702D9, 24'hC800A8, 24'hCA02DA, 24'hCB00B8, 24'hCD02DD, 24'hCE02DB,
    24'hCF02C7, 24'hD02014, 24'hE100C6, 24'hE300AA, 24'hE80141, 24'hE900D8, 24'hEA0152,
    24'hEB00BA, 24'hF100E6, 24'hF50131, 24'hF80142, 24'hF900F8, 24'hFA0153, 24'hFB00DF
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_code = '0;
  logic [31:0] in_new_scalar = '0;
  logic [8:0]  in_kept_entries = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_0, out_byte_1, out_byte_2, out_byte_3;
  logic [2:0]  out_byte_count, out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_base_encoding = '0;

  font_code_to_utf8_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_code(in_code),
    .in_new_scalar(in_new_scalar), .in_kept_entries(in_kept_entries),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte_0(out_byte_0), .out_byte_1(out_byte_1), .out_byte_2(out_byte_2),
    .out_byte_3(out_byte_3), .out_byte_count(out_byte_count), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_base_encoding(cfg_base_encoding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  glyph_req_t pending_reqs[$];
  res_t       expected_utf8[$];
  int         mismatches = 0;
  int         results_seen = 0;

  // shadow of the decoder state
  logic [7:0]  diff_code [TABLE_DEPTH];
  logic [31:0] diff_map [TABLE_DEPTH];
  int          entries = 0;
  int          written_prefix = 0;  // entries 0..prefix-1 hold written data
  logic [3:0]  base_sel = 4'd0;

  function automatic logic [31:0] pair_find(input bit use_std, input logic [7:0] c);
    logic [31:0] s;
    s = 0;
    if (use_std) begin
      foreach (STD_PAIRS[i]) if (STD_PAIRS[i][23:16] == c) s = STD_PAIRS[i][15:0];
    end else begin
      foreach (DOC_PAIRS[i]) if (DOC_PAIRS[i][23:16] == c) s = DOC_PAIRS[i][15:0];
    end
    return s;
  endfunction

  function automatic logic [31:0] base_scalar(input logic [3:0] b, input logic [7:0] c);
    logic [31:0] sm;
    logic [31:0] sd;
    sm = pair_find(1'b1, c);
    sd = pair_find(1'b0, c);
    if (b == 5 && c == "c") return 32'h03B3;
    if (b == 5 && c == "d") return 32'h03B4;
    if (b == 5 && c == "l") return 32'h03BB;
    if (b == 8 && c == "o") return 32'h2610;
    if (b == 9 && c == 8'hD3) return 32'h2191;
    if (b == 3 && sm != 0) return sm;
    if (c >= 8'h20 && c <= 8'h7E) return c;
    case (b)
      4'd0: return (c >= 8'hA0) ? c : (c[7] ? WIN_HI[c[4:0]] : 0);
      4'd1: return c[7] ? MAC_HI[c[6:0]] : 0;
      4'd2: return (sd != 0) ? sd : ((c >= 8'hA1) ? c : 0);
      4'd4: return (c == 0) ? 32'h2212 : sm;
      4'd6: return (c == 2) ? 32'h00B0 : (c == 3) ? 32'h223C : (c == 4) ? 32'h2248 : sm;
      4'd7: return (c == 2) ? 32'h030C : (c == 3) ? 32'h0301 : sm;
      4'd3, 4'd5: return sm;
      default: return 0;
    endcase
  endfunction

  function automatic res_t utf8_of(input logic [31:0] s);
    res_t r;
    int   len;
    r = '0;
    r.st = ST_OK;
    if (s & PACKED_BIT) begin
      len = s[30:24];
      if (len < 2 || len > 3) begin
        r.st = ST_MALFORMED;
      end else begin
        r.b0 = s[23:16];
        r.b1 = s[15:8];
        if (len == 3) r.b2 = s[7:0];
        r.n = len;
      end
    end else if (s >= 32'hFB00 && s <= 32'hFB06) begin
      case (s[2:0])
        3'd0: begin r.b0 = "f"; r.b1 = "f"; r.n = 2; end
        3'd1: begin r.b0 = "f"; r.b1 = "i"; r.n = 2; end
        3'd2: begin r.b0 = "f"; r.b1 = "l"; r.n = 2; end
        3'd3: begin r.b0 = "f"; r.b1 = "f"; r.b2 = "i"; r.n = 3; end
        3'd4: begin r.b0 = "f"; r.b1 = "f"; r.b2 = "l"; r.n = 3; end
        default: begin r.b0 = "s"; r.b1 = "t"; r.n = 2; end
      endcase
    end else if (s < 32'h80) begin
      r.b0 = s[7:0];
      r.n = 1;
    end else if (s < 32'h800) begin
      r.b0 = 8'hC0 | s[10:6];
      r.b1 = 8'h80 | s[5:0];
      r.n = 2;
    end else if (s < 32'h10000) begin
      if (s >= 32'hD800 && s <= 32'hDFFF) begin
        r.st = ST_INVALID;
      end else begin
        r.b0 = 8'hE0 | s[15:12];
        r.b1 = 8'h80 | s[11:6];
        r.b2 = 8'h80 | s[5:0];
        r.n = 3;
      end
    end else if (s <= 32'h10FFFF) begin
      r.b0 = 8'hF0 | s[20:18];
      r.b1 = 8'h80 | s[17:12];
      r.b2 = 8'h80 | s[11:6];
      r.b3 = 8'h80 | s[5:0];
      r.n = 4;
    end else begin
      r.st = ST_INVALID;
    end
    return r;
  endfunction

  // advances the shadow state by one request and returns its result
  function automatic res_t decode_glyph(input glyph_req_t q);
    res_t        r;
    logic [31:0] s;
    r = '0;
    r.st = ST_OK;
    case (q.mode)
      MODE_ADD: begin
        if (entries >= TABLE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          diff_code[entries] = q.code;
          diff_map[entries] = q.scalar;
          if (entries == written_prefix) written_prefix++;
          entries++;
        end
      end
      MODE_CLEAR: begin
        if (q.kept > TABLE_DEPTH) r.st = ST_BAD_KEEP;
        else entries = q.kept;
      end
      MODE_DECODE: begin
        s = 0;
        for (int i = entries - 1; i >= 0; i--) begin
          if (diff_code[i] == q.code) begin
            s = diff_map[i];
            break;
          end
        end
        if (s == 0) s = base_scalar(base_sel, q.code);
        if (s == 0) r.st = ST_UNMAPPED;
        else r = utf8_of(s);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(input mode_t m, input logic [7:0] c, input logic [31:0] s,
                           input logic [8:0] k);
    glyph_req_t q;
    q.mode = m;
    q.code = c;
    q.scalar = s;
    q.kept = k;
    expected_utf8.push_back(decode_glyph(q));
    pending_reqs.push_back(q);
  endtask

  function automatic logic [31:0] rand_scalar();
    case ($urandom_range(0, 11))
      0: return $urandom_range(1, 8'h7F);
      1: return $urandom_range(8'h80, 16'h7FF);
      2: return $urandom_range(16'h800, 16'hFFFF);
      3: return $urandom_range(16'hD800, 16'hDFFF);
      4: return $urandom_range(32'h10000, 32'h10FFFF);
      5: return $urandom_range(32'hFB00, 32'hFB06);
      6: return PACKED_BIT | ($urandom_range(2, 3) << 24) | $urandom_range(0, 24'hFFFFFF);
      7: return PACKED_BIT | $urandom();
      8: return 0;
      9: return $urandom_range(32'h110000, 32'h7FFFFFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] rand_code();
    logic [7:0] hot [16] = '{8'h00, 8'h02, 8'h03, 8'h04, "c", "d", "l", "o", 8'hD3,
                             8'h27, 8'h60, 8'h80, 8'h9F, 8'hA0, 8'hFF, 8'h41};
    case ($urandom_range(0, 3))
      0: return hot[$urandom_range(0, 15)];
      1: return 8'h41 + $urandom_range(0, 7);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic queue_random(input int count);
    int   pick;
    logic [8:0] k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      // decoding over never-written entries is not allowed: clear first
      if (entries > written_prefix && pick < 60) pick = 90;
      if (pick < 60) begin
        queue_req(MODE_DECODE, rand_code(), $urandom(), $urandom_range(0, 511));
      end else if (pick < 85) begin
        queue_req(MODE_ADD, rand_code(), rand_scalar(), $urandom_range(0, 511));
      end else if (pick < 96) begin
        case ($urandom_range(0, 9))
          7: k = $urandom_range(TABLE_DEPTH + 1, 511);
          8: k = (written_prefix < TABLE_DEPTH) ?
                 $urandom_range(written_prefix + 1, TABLE_DEPTH) : TABLE_DEPTH;
          9: k = 0;
          default: k = $urandom_range(0, (written_prefix < 24) ? written_prefix : 24);
        endcase
        queue_req(MODE_CLEAR, $urandom(), $urandom(), k);
      end else begin
        queue_req(MODE_NONE, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // send beat: bursts of random length with random gaps
  int send_burst = 0;
  int send_gap = 0;
  always @(posedge clk) begin : sender
    glyph_req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        q = pending_reqs.pop_front();
        in_mode <= q.mode;
        in_code <= q.code;
        in_new_scalar <= q.scalar;
        in_kept_entries <= q.kept;
        in_valid <= 1'b1;
        if (send_burst <= 1) begin
          send_burst <= $urandom_range(1, 40);
          send_gap <= $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
        end else begin
          send_burst <= send_burst - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result beat: own stall pattern, one long hold once the run is underway
  int   hold_left = 0;
  bit   held_once = 0;
  logic [9:0] stall_phase = '0;
  always @(posedge clk) begin : receiver
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_count,
                status_t'(out_status)};
        results_seen <= results_seen + 1;
        if (expected_utf8.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = expected_utf8.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %h %h n=%0d st=%0d, got %h %h %h %h n=%0d st=%0d",
                       want.b0, want.b1, want.b2, want.b3, want.n, want.st,
                       got.b0, got.b1, got.b2, got.b3, got.n, got.st);
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen >= 600) begin
        held_once <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= stall_phase[8] ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_utf8.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_base(input logic [3:0] b);
    cfg_base_encoding <= b;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_sel = b;
  endtask

  initial begin : stimulus
    logic [3:0] bases [16] = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                               4'd7, 4'd8, 4'd9, 4'd10, 4'd12, 4'd0, 4'd9, 4'd0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fall-through, packed, ligature, utf-8 boundaries and failures
    queue_req(MODE_DECODE, 8'h41, 0, 0);
    queue_req(MODE_DECODE, 8'h00, 0, 0);
    queue_req(MODE_DECODE, 8'hFF, 0, 0);
    queue_req(MODE_DECODE, 8'h81, 0, 0);
    queue_req(MODE_ADD, 8'h41, 32'hFB03, 0);
    queue_req(MODE_DECODE, 8'h41, 0, 0);
    queue_req(MODE_ADD, 8'h41, 32'h0, 0);
    queue_req(MODE_DECODE, 8'h41, 0, 0);
    queue_req(MODE_ADD, 8'h42, 32'h8378797A, 0);
    queue_req(MODE_ADD, 8'h43, 32'h82FF6162, 0);
    queue_req(MODE_ADD, 8'h44, 32'hFF000000, 0);
    queue_req(MODE_ADD, 8'h45, 32'h0000D800, 0);
    queue_req(MODE_ADD, 8'h46, 32'h00110000, 0);
    queue_req(MODE_ADD, 8'h47, 32'h0010FFFF, 0);
    queue_req(MODE_ADD, 8'h48, 32'h000007FF, 0);
    for (int c = 8'h42; c <= 8'h48; c++) queue_req(MODE_DECODE, c, 0, 0);
    queue_req(MODE_CLEAR, 8'h00, 0, 9'd257);
    queue_req(MODE_CLEAR, 8'hFF, 32'hFFFFFFFF, 9'd511);
    queue_req(MODE_NONE, 8'hFF, 32'hFFFFFFFF, 9'h1FF);
    queue_req(MODE_CLEAR, 8'h00, 0, 9'd0);
    queue_req(MODE_DECODE, 8'h41, 0, 0);
    wait_drained();

    foreach (bases[p]) begin
      write_base(bases[p]);
      if (p == 4) begin
        // fill the whole table, overflow it, decode at full depth
        queue_req(MODE_CLEAR, 0, 0, 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
          queue_req(MODE_ADD, rand_code(), rand_scalar(), 0);
        queue_req(MODE_ADD, 8'h41, 32'h41, 0);
        for (int i = 0; i < 6; i++) queue_req(MODE_DECODE, rand_code(), 0, 0);
        queue_req(MODE_CLEAR, 0, 0, 9'd256);
        queue_req(MODE_DECODE, 8'h00, 0, 0);
        queue_req(MODE_CLEAR, 0, 0, 9'd3);
      end
      queue_random(110);
      if (p == 7) begin
        // stimulus queues no more until every result is back
        while (expected_utf8.size() != 0) @(posedge clk);
      end
      queue_random(10);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("PASS font_code_to_utf8_decoder");
    else $display("FAIL font_code_to_utf8_decoder");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("FAIL font_code_to_utf8_decoder");
    $finish;
  end

endmodule
